### rtl/core/kvt_pkg.sv
`timescale 1ns / 1ps

package kvt_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 32;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t               cmd;
        logic [31:0]        key;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        status_t            status;
        logic [31:0]        out_key;
        logic signed [31:0] out_value;
        logic [4:0]         entry_count;
        logic               is_empty;
        logic               is_full;
        logic               last;
    } out_t;

    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic signed [31:0] value;
    } entry_t;

    typedef struct packed {
        entry_t entry;
        logic   keeps;
    } sort_link_t;

    typedef enum logic [1:0] {
        TBL_HOLD  = 2'd0,
        TBL_LOAD  = 2'd1,
        TBL_SHIFT = 2'd2
    } tbl_op_t;

    typedef enum logic [1:0] {
        SORT_HOLD   = 2'd0,
        SORT_CLEAR  = 2'd1,
        SORT_INSERT = 2'd2,
        SORT_SHIFT  = 2'd3
    } sort_op_t;

endpackage

### rtl/core/kvt_table_cell.sv
`timescale 1ns / 1ps

module kvt_table_cell
    import kvt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_op_t          op,
    input  entry_t           load_entry,
    input  entry_t           next_entry,
    input  logic [KEY_W-1:0] probe_key,
    output entry_t           entry,
    output logic             match
);

    logic               valid_reg;
    logic [KEY_W-1:0]   key_reg;
    logic signed [31:0] value_reg;
    entry_t             entry_next;

    always_comb
    begin
        entry_next = entry;
        unique case (op)
            TBL_HOLD:  entry_next = entry;
            TBL_LOAD:  entry_next = load_entry;
            TBL_SHIFT: entry_next = next_entry;
            default:   entry_next = entry;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= entry_next.key;
        value_reg <= entry_next.value;
    end

    assign entry = '{valid: valid_reg, key: key_reg, value: value_reg};
    assign match = valid_reg && (key_reg == probe_key);

endmodule

### rtl/core/kvt_sort_cell.sv
`timescale 1ns / 1ps

module kvt_sort_cell
    import kvt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  sort_op_t   op,
    input  entry_t     new_entry,
    input  sort_link_t prev_link,
    input  entry_t     next_entry,
    output sort_link_t link
);

    logic               valid_reg;
    logic [KEY_W-1:0]   key_reg;
    logic signed [31:0] value_reg;
    entry_t             self;
    entry_t             entry_next;

    assign self = '{valid: valid_reg, key: key_reg, value: value_reg};

    always_comb
    begin
        entry_next = self;
        unique case (op)
            SORT_HOLD:
            begin
                entry_next = self;
            end
            SORT_CLEAR:
            begin
                entry_next       = self;
                entry_next.valid = 1'b0;
            end
            SORT_INSERT:
            begin
                priority if (link.keeps)
                    entry_next = self;
                else if (prev_link.keeps)
                    entry_next = new_entry;
                else
                    entry_next = prev_link.entry;
            end
            SORT_SHIFT:
            begin
                entry_next = next_entry;
            end
            default:
            begin
                entry_next = self;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= entry_next.key;
        value_reg <= entry_next.value;
    end

    assign link.entry = self;
    assign link.keeps = valid_reg && (value_reg >= new_entry.value);

endmodule

### rtl/core/key_value_table_sorted_dump.sv
`timescale 1ns / 1ps
// Lookup, insert, delete: EXEC forms the result, which is registered; the next
// start is taken in the cycle the result shows, so commands never overlap.
// Dump: EXEC clears the sort row, LOAD rotates the table row into it one entry
// at a time, then EMIT gives one result per entry.
// Dump of an empty table gives a single beat. Results cannot stall.
// Reset (async, active low) empties the table and sets undefined_value to -1.

module key_value_table_sorted_dump
    import kvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_t         request,
    output logic        done,
    output out_t        result,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD,
        S_EMIT
    } state_t;

    state_t             state_reg, state_next;
    in_t                req_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic signed [31:0] undef_reg;
    logic               done_reg, done_next;
    out_t               result_reg, result_next;

    logic [KEY_W-1:0]   probe_key;
    entry_t             tbl [DEPTH];
    entry_t             tbl_next_in [DEPTH];
    logic [DEPTH-1:0]   match;
    logic [DEPTH-1:0]   after;
    logic [DEPTH-1:0]   ins;
    tbl_op_t            tbl_op [DEPTH];
    sort_link_t         srt [DEPTH];
    sort_link_t         srt_prev_in [DEPTH];
    entry_t             srt_next_in [DEPTH];
    sort_op_t           sort_op;
    entry_t             new_entry;
    logic               hit;
    logic               full;
    logic signed [31:0] found;
    logic               rotate;

    assign probe_key = KEY_W'(req_reg.key);
    assign rotate    = (state_reg == S_LOAD);
    assign new_entry = '{valid: 1'b1, key: probe_key, value: req_reg.value};
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign hit       = |match;

    always_comb
    begin
        found = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            found = found | (tbl[i].value & {32{match[i]}});
            after[i] = match[i] | ((i > 0) ? after[(i > 0) ? i - 1 : 0] : 1'b0);
            ins[i]   = !tbl[i].valid && ((i == 0) || tbl[(i > 0) ? i - 1 : 0].valid);
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            if (g == DEPTH - 1)
            begin : g_end
                assign tbl_next_in[g] = rotate ? tbl[0] : '0;
                assign srt_next_in[g] = '0;
            end
            else
            begin : g_mid
                assign tbl_next_in[g] = tbl[g+1];
                assign srt_next_in[g] = srt[g+1].entry;
            end

            if (g == 0)
            begin : g_head
                assign srt_prev_in[g] = '{entry: '0, keeps: 1'b1};
            end
            else
            begin : g_body
                assign srt_prev_in[g] = srt[g-1];
            end

            kvt_table_cell u_tcell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (tbl_op[g]),
                .load_entry (new_entry),
                .next_entry (tbl_next_in[g]),
                .probe_key  (probe_key),
                .entry      (tbl[g]),
                .match      (match[g])
            );

            kvt_sort_cell u_scell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (sort_op),
                .new_entry  (tbl[0]),
                .prev_link  (srt_prev_in[g]),
                .next_entry (srt_next_in[g]),
                .link       (srt[g])
            );
        end
    endgenerate

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        sort_op     = SORT_HOLD;
        for (int i = 0; i < DEPTH; i++)
        begin
            tbl_op[i] = TBL_HOLD;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                result_next.out_key   = 32'(probe_key);
                result_next.out_value = req_reg.value;
                result_next.status    = ST_OK;
                result_next.last      = 1'b1;
                done_next             = 1'b1;
                state_next            = S_IDLE;
                unique case (req_reg.cmd)
                    CMD_LOOKUP:
                    begin
                        result_next.status    = hit ? ST_OK : ST_NOT_FOUND;
                        result_next.out_value = hit ? found : undef_reg;
                    end
                    CMD_INSERT:
                    begin
                        priority if (hit)
                        begin
                            result_next.status    = ST_DUPLICATE;
                            result_next.out_value = found;
                        end
                        else if (full)
                        begin
                            result_next.status = ST_FULL;
                        end
                        else
                        begin
                            count_next = count_reg + CNT_W'(1);
                            for (int i = 0; i < DEPTH; i++)
                            begin
                                tbl_op[i] = ins[i] ? TBL_LOAD : TBL_HOLD;
                            end
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (hit)
                        begin
                            result_next.out_value = found;
                            count_next            = count_reg - CNT_W'(1);
                            for (int i = 0; i < DEPTH; i++)
                            begin
                                tbl_op[i] = after[i] ? TBL_SHIFT : TBL_HOLD;
                            end
                        end
                        else
                        begin
                            result_next.status    = ST_NOT_FOUND;
                            result_next.out_value = undef_reg;
                        end
                    end
                    CMD_DUMP:
                    begin
                        if (count_reg == '0)
                        begin
                            result_next.status    = ST_EMPTY;
                            result_next.out_key   = '0;
                            result_next.out_value = '0;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            sort_op    = SORT_CLEAR;
                            step_next  = '0;
                            state_next = S_LOAD;
                        end
                    end
                    default:
                    begin
                        result_next.status = ST_OK;
                    end
                endcase
            end
            S_LOAD:
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    tbl_op[i] = TBL_SHIFT;
                end
                sort_op   = tbl[0].valid ? SORT_INSERT : SORT_HOLD;
                step_next = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(DEPTH - 1))
                begin
                    step_next  = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                sort_op               = SORT_SHIFT;
                done_next             = 1'b1;
                result_next.status    = ST_OK;
                result_next.out_key   = 32'(srt[0].entry.key);
                result_next.out_value = srt[0].entry.value;
                result_next.last      = (step_reg == IDX_W'(count_reg - CNT_W'(1)));
                step_next             = step_reg + IDX_W'(1);
                if (result_next.last)
                begin
                    step_next  = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        result_next.entry_count = 5'(count_next);
        result_next.is_empty    = (count_next == '0);
        result_next.is_full     = (count_next == CNT_W'(DEPTH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            step_reg   <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
            undef_reg  <= -32'sd1;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            done_reg   <= done_next;
            result_reg <= result_next;
            if (cfg_we)
            begin
                undef_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= request;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

### rtl/core/kvt_checker.sv
`timescale 1ns / 1ps

module kvt_checker
    import kvt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input out_t        result
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted command");

    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.last |-> !busy)
        else $error("block still busy on final beat");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.last |-> busy)
        else $error("block idle with beats outstanding");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.is_empty == (result.entry_count == 5'd0)))
        else $error("empty flag disagrees with entry count");

    a_empty_dump: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_EMPTY |-> result.last && result.entry_count == 5'd0)
        else $error("empty dump beat malformed");

endmodule

bind key_value_table_sorted_dump kvt_checker u_kvt_checker (.*);

### test/key_value_table_sorted_dump_tb.sv
`timescale 1ns / 1ps

module key_value_table_sorted_dump_tb;
    import kvt_pkg::*;

    localparam int POOL_SIZE = 24;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 2 * DEPTH + 8;

    class kv_scoreboard;
        out_t                expected_q[$];
        logic [31:0]         keys[DEPTH];
        logic signed [31:0]  vals[DEPTH];
        int unsigned         count;
        logic signed [31:0]  undef_val;
        int                  errors;
        int                  n_cmds;
        int                  n_beats;
        int                  n_dumps;
        int                  n_refused;
        int                  n_dups;

        function new();
            count = 0;
            undef_val = -1;
            errors = 0;
            n_cmds = 0;
            n_beats = 0;
            n_dumps = 0;
            n_refused = 0;
            n_dups = 0;
        endfunction

        function int find_key(logic [31:0] k);
            for (int i = 0; i < count; i++)
                if (keys[i] == k)
                    return i;
            return -1;
        endfunction

        function void push_beat(status_t st, logic [31:0] k, logic signed [31:0] v,
                                bit last_beat);
            out_t beat;
            beat.status      = st;
            beat.out_key     = k;
            beat.out_value   = v;
            beat.entry_count = count[4:0];
            beat.is_empty    = (count == 0);
            beat.is_full     = (count >= DEPTH);
            beat.last        = last_beat;
            expected_q.push_back(beat);
        endfunction

        function void note_command(in_t item);
            int                 pos;
            int                 j;
            logic [31:0]        sk[DEPTH];
            logic signed [31:0] sv[DEPTH];
            logic signed [31:0] removed;
            n_cmds++;
            pos = find_key(item.key);
            case (item.cmd)
                CMD_LOOKUP:
                begin
                    if (pos >= 0)
                        push_beat(ST_OK, item.key, vals[pos], 1'b1);
                    else
                        push_beat(ST_NOT_FOUND, item.key, undef_val, 1'b1);
                end
                CMD_INSERT:
                begin
                    if (pos >= 0)
                    begin
                        n_dups++;
                        push_beat(ST_DUPLICATE, item.key, vals[pos], 1'b1);
                    end
                    else if (count >= DEPTH)
                    begin
                        n_refused++;
                        push_beat(ST_FULL, item.key, item.value, 1'b1);
                    end
                    else
                    begin
                        keys[count] = item.key;
                        vals[count] = item.value;
                        count++;
                        push_beat(ST_OK, item.key, item.value, 1'b1);
                    end
                end
                CMD_DELETE:
                begin
                    if (pos >= 0)
                    begin
                        removed = vals[pos];
                        for (int i = pos; i + 1 < count; i++)
                        begin
                            keys[i] = keys[i + 1];
                            vals[i] = vals[i + 1];
                        end
                        count--;
                        push_beat(ST_OK, item.key, removed, 1'b1);
                    end
                    else
                        push_beat(ST_NOT_FOUND, item.key, undef_val, 1'b1);
                end
                default:
                begin
                    n_dumps++;
                    if (count == 0)
                        push_beat(ST_EMPTY, '0, '0, 1'b1);
                    else
                    begin
                        // stable descending order: equal values keep insertion order
                        for (int i = 0; i < count; i++)
                        begin
                            j = i;
                            while (j > 0 && sv[j - 1] < vals[i])
                            begin
                                sk[j] = sk[j - 1];
                                sv[j] = sv[j - 1];
                                j--;
                            end
                            sk[j] = keys[i];
                            sv[j] = vals[i];
                        end
                        for (int i = 0; i < count; i++)
                            push_beat(ST_OK, sk[i], sv[i], i + 1 == count);
                    end
                end
            endcase
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_beat(out_t got);
            out_t exp;
            n_beats++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected beat key %h value %0d", got.out_key,
                                 got.out_value));
                return;
            end
            exp = expected_q.pop_front();
            if (got.status !== exp.status)
                report($sformatf("status %0d, want %0d", got.status, exp.status));
            if (got.out_key !== exp.out_key)
                report($sformatf("out_key %h, want %h", got.out_key, exp.out_key));
            if (got.out_value !== exp.out_value)
                report($sformatf("out_value %0d, want %0d", got.out_value,
                                 exp.out_value));
            if (got.entry_count !== exp.entry_count)
                report($sformatf("entry_count %0d, want %0d", got.entry_count,
                                 exp.entry_count));
            if (got.is_empty !== exp.is_empty)
                report($sformatf("is_empty %b, want %b", got.is_empty, exp.is_empty));
            if (got.is_full !== exp.is_full)
                report($sformatf("is_full %b, want %b", got.is_full, exp.is_full));
            if (got.last !== exp.last)
                report($sformatf("last %b, want %b", got.last, exp.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_t         request;
    logic        done;
    out_t        result;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    kv_scoreboard sb = new();
    logic [31:0]  key_pool[POOL_SIZE];
    int           sender_idle;
    int           cycles;
    bit           growing;

    key_value_table_sorted_dump u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_beat(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send_cmd(cmd_t c, logic [31:0] k, logic signed [31:0] v);
        in_t item;
        item.cmd   = c;
        item.key   = k;
        item.value = v;
        while ($urandom_range(99) < sender_idle)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= item;
        do
            @(posedge clk);
        while (busy);
        sb.note_command(item);
    endtask

    task automatic drain();
        if (sb.expected_q.size() == 0)
            return;
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_undef(logic [31:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.undef_val = v;
    endtask

    function automatic logic signed [31:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 32'sh8000_0000;
        if (r == 1)
            return 32'sh7fff_ffff;
        if (r < 5)
            return $urandom_range(3) - 1;
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_key(bit stored_bias);
        if ($urandom_range(9) == 0)
            return $urandom();
        if (stored_bias && sb.count > 0 && $urandom_range(9) < 8)
            return sb.keys[$urandom_range(sb.count - 1)];
        return key_pool[$urandom_range(POOL_SIZE - 1)];
    endfunction

    task automatic run_random(int n_items);
        int r;
        for (int i = 0; i < n_items; i++)
        begin
            if (sb.count >= DEPTH)
                growing = 1'b0;
            else if (sb.count == 0)
                growing = 1'b1;
            // now and then, hold off until the table has answered everything
            if ($urandom_range(59) == 0)
                drain();
            r = $urandom_range(99);
            if (r < 8)
                send_cmd(CMD_DUMP, $urandom(), $urandom());
            else if (r < 38)
                send_cmd(CMD_LOOKUP, pick_key(1'b1), $urandom());
            else if ((r < 69) == growing)
                send_cmd(CMD_INSERT, pick_key(1'b0), pick_value());
            else
                send_cmd(CMD_DELETE, pick_key(1'b1), $urandom());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        request     = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        cycles      = 0;
        sender_idle = 28;
        growing     = 1'b1;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hffff_ffff;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = $urandom();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(CMD_DUMP, 32'h0, 32'sh0);
        send_cmd(CMD_LOOKUP, 32'h0, 32'sh0);
        send_cmd(CMD_DELETE, 32'hffff_ffff, 32'sh0);
        send_cmd(CMD_INSERT, 32'h0000_0000, 32'sh8000_0000);
        send_cmd(CMD_INSERT, 32'hffff_ffff, 32'sh7fff_ffff);
        send_cmd(CMD_INSERT, 32'h0000_0000, 32'sh5);
        send_cmd(CMD_LOOKUP, 32'hffff_ffff, 32'sh0);
        send_cmd(CMD_INSERT, 32'ha5a5_a5a5, 32'sh7fff_ffff);
        send_cmd(CMD_INSERT, 32'h5a5a_5a5a, 32'sh0);
        send_cmd(CMD_DUMP, 32'hffff_ffff, 32'shffff_ffff);
        send_cmd(CMD_DELETE, 32'h0000_0000, 32'sh0);
        for (int i = 0; i < DEPTH - 3; i++)
            send_cmd(CMD_INSERT, key_pool[i + 2], pick_value());
        send_cmd(CMD_INSERT, 32'h1234_5678, 32'sh7fff_ffff);
        send_cmd(CMD_DUMP, 32'h0, 32'sh0);

        write_undef(32'h8000_0000);
        run_random(145);

        sender_idle = 64;
        write_undef(32'h7fff_ffff);
        run_random(145);

        sender_idle = 0;
        write_undef($urandom());
        run_random(145);

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d commands and %0d result beats: %0d dumps, %0d inserts refused",
                 sb.n_cmds, sb.n_beats, sb.n_dumps, sb.n_refused);
        $display("on a full table, %0d duplicate inserts, four undefined-value settings",
                 sb.n_dups);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
